@@ rtl/barometer_temp_pressure_compensation_macros.svh @@
// Assertion macros shared by the barometer compensation RTL.
`ifndef BAROMETER_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BAROMETER_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define BPC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define BPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BPC_ASSERT_IMPL(lbl, ante, cons)
`define BPC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/bpc_pkg.sv @@
// Types and constants for the barometer compensation block.
`default_nettype none

package bpc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned RAW_W  = 19;

	typedef logic [WORD_W-1:0] word_t;

	// Register index decoded from paddr[4:3]
	typedef enum logic [1:0] {
		REG_TEMP_CAL  = 2'd0,
		REG_PRESS_CAL = 2'd1,
		REG_PRESS_B   = 2'd2,
		REG_OSS       = 2'd3
	} reg_idx_t;

	localparam word_t B6_OFFSET   = 32'd4000;
	localparam word_t X3_BIAS     = 32'd32768;
	localparam word_t B7_SCALE    = 32'd50000;
	localparam word_t P_SQ_COEF   = 32'd3038;
	localparam word_t P_LIN_COEF  = 32'hFFFF_E343; // -7357
	localparam word_t P_OFFSET    = 32'd3791;
	localparam word_t SIGN_BIT    = 32'h8000_0000;

	function automatic word_t sx16(input logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	function automatic word_t asr(input word_t x, input logic [4:0] n);
		return word_t'($signed(x) >>> n);
	endfunction

endpackage : bpc_pkg

`default_nettype wire

@@ rtl/bpc_in_if.sv @@
// Raw conversion channel: op and raw reading.
`default_nettype none

interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [18:0] raw_value;

	modport source(output valid, output op, output raw_value, input ready);
	modport sink(input valid, input op, input raw_value, output ready);
endinterface : bpc_in_if

`default_nettype wire

@@ rtl/bpc_out_if.sv @@
// Compensated result channel.
`default_nettype none

interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] value;
	logic               div_error;

	modport source(output valid, output kind, output value, output div_error, input ready);
	modport sink(input valid, input kind, input value, input div_error, output ready);
endinterface : bpc_out_if

`default_nettype wire

@@ rtl/bpc_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
`default_nettype none

module bpc_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bpc_pkg::word_t num,
	input  wire bpc_pkg::word_t den,
	output logic               busy,
	output logic               done,
	output bpc_pkg::word_t     quot
);
	import bpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W);

	word_t            rem_q;
	word_t            quo_q;
	word_t            den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WORD_W:0] rem_sh;
	logic [WORD_W:0] diff;

	assign rem_sh = {rem_q, quo_q[WORD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quo_q;

endmodule : bpc_div

`default_nettype wire

@@ rtl/barometer_temp_pressure_compensation.sv @@
// Top level: barometer temperature and pressure compensation sequencer.
`default_nettype none
`include "barometer_temp_pressure_compensation_macros.svh"

// Datasheet integer compensation for a barometric sensor. Each transfer on
// raw carries one uncompensated conversion: op 0 is a temperature reading,
// op 1 a pressure reading. A temperature item yields tenths of a degree C and
// stores the intermediate B5; a pressure item uses the stored B5 (zero after
// reset) and yields pascal. All math is 32-bit two's complement with
// wraparound. Every item gives exactly one transfer on comp; a zero divisor
// gives div_error 1 and value 0 (a failed temperature item keeps the old B5).
// One item is in work at a time: raw.ready is high only while idle. The
// bit-serial divider dominates the time an item takes, the rest being one
// step per cycle through the single 32x32 multiplier; a zero divisor skips
// the divider. The result sits in an output register, so the next item can
// be taken while it waits; a second result stalls in the done step until
// that register drains.
// Calibration is written over APB, 64-bit data, register i at byte 8*i:
// 0 temp_cal_words, 1 pressure_cal_words, 2 pressure_cal_b, 3 oversampling.
// Write registers only while the block is idle.

module barometer_temp_pressure_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	bpc_in_if.sink           raw,
	bpc_out_if.source        comp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import bpc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_T1, S_T2, S_T3, S_TDIV,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_PDIV,
		S_P10, S_P11, S_P12, S_P13, S_DONE
	} state_t;

	// ---------------- configuration registers ----------------
	logic [63:0] temp_cal_q;
	logic [63:0] press_cal_q;
	logic [31:0] press_b_q;
	logic [1:0]  oss_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q  <= '0;
			press_cal_q <= '0;
			press_b_q   <= '0;
			oss_q       <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TEMP_CAL:  temp_cal_q  <= pwdata;
				REG_PRESS_CAL: press_cal_q <= pwdata;
				REG_PRESS_B:   press_b_q   <= pwdata[31:0];
				REG_OSS:       oss_q       <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TEMP_CAL:  prdata = temp_cal_q;
			REG_PRESS_CAL: prdata = press_cal_q;
			REG_PRESS_B:   prdata = {32'd0, press_b_q};
			REG_OSS:       prdata = {62'd0, oss_q};
			default:       prdata = '0;
		endcase
	end

	// calibration fields, widened to 32 bits
	word_t ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;
	assign ac5 = {16'd0, temp_cal_q[63:48]};
	assign ac6 = {16'd0, temp_cal_q[47:32]};
	assign mc  = sx16(temp_cal_q[31:16]);
	assign md  = sx16(temp_cal_q[15:0]);
	assign ac1 = sx16(press_cal_q[63:48]);
	assign ac2 = sx16(press_cal_q[47:32]);
	assign ac3 = sx16(press_cal_q[31:16]);
	assign ac4 = {16'd0, press_cal_q[15:0]};
	assign b1  = sx16(press_b_q[31:16]);
	assign b2  = sx16(press_b_q[15:0]);

	// ---------------- sequencer state ----------------
	state_t      state_q;
	logic        op_q;
	logic [18:0] raw_q;
	word_t       ti_q;      // stored B5
	word_t       p_q;       // multiplier output register
	word_t       x1_q;      // accumulator for partial terms
	word_t       den_q;
	word_t       sq_q;
	word_t       b3_q;
	word_t       b4_q;
	word_t       pv_q;      // raw pressure before the final correction
	word_t       res_q;
	logic        err_q;
	logic        neg_q;     // temperature quotient sign
	logic        dbl_q;     // pressure numerator was doubled before the divide

	logic        out_valid_q;
	logic        out_kind_q;
	word_t       out_value_q;
	logic        out_err_q;

	// derived values
	word_t b6, raw_w, mc_sh, num_abs, den_abs, b5, q_s, b3_next, x3_next;
	word_t p_final, temp_res;
	logic  in_xfer, out_free;

	assign raw_w   = {13'd0, raw_q};
	assign b6      = ti_q - B6_OFFSET;
	assign mc_sh   = mc << 11;
	assign num_abs = mc_sh[31] ? (~mc_sh + 1'b1) : mc_sh;
	assign den_abs = den_q[31] ? (~den_q + 1'b1) : den_q;
	assign b3_next = asr(((((ac1 << 2) + x1_q + asr(p_q, 5'd11)) << oss_q) + 32'd2), 5'd2);
	assign x3_next = asr(x1_q + asr(p_q, 5'd16) + 32'd2, 5'd2) + X3_BIAS;
	assign p_final = pv_q + asr(x1_q + asr(p_q, 5'd16) + P_OFFSET, 5'd4);

	// ---------------- shared multiplier ----------------
	word_t mul_a, mul_b, mul_y;

	always_comb begin
		case (state_q)
			S_T1:  begin mul_a = raw_w - ac6;           mul_b = ac5;                end
			S_P1:  begin mul_a = b6;                    mul_b = b6;                 end
			S_P2:  begin mul_a = b2;                    mul_b = asr(p_q, 5'd12);    end
			S_P3:  begin mul_a = ac2;                   mul_b = b6;                 end
			S_P4:  begin mul_a = ac3;                   mul_b = b6;                 end
			S_P5:  begin mul_a = b1;                    mul_b = sq_q;               end
			S_P7:  begin mul_a = ac4;                   mul_b = x1_q;               end
			S_P8:  begin mul_a = raw_w - b3_q;          mul_b = B7_SCALE >> oss_q;  end
			S_P10: begin mul_a = asr(pv_q, 5'd8);       mul_b = asr(pv_q, 5'd8);    end
			S_P11: begin mul_a = p_q;                   mul_b = P_SQ_COEF;          end
			S_P12: begin mul_a = P_LIN_COEF;            mul_b = pv_q;               end
			default: begin mul_a = '0;                  mul_b = '0;                 end
		endcase
	end

	assign mul_y = mul_a * mul_b;

	// ---------------- shared divider ----------------
	logic  div_start, div_busy, div_done;
	word_t div_num, div_den, div_quot;

	assign div_start = (state_q == S_T3 && den_q != '0) || (state_q == S_P9 && b4_q != '0);
	assign div_num   = (state_q == S_T3) ? num_abs : (p_q[31] ? p_q : (p_q << 1));
	assign div_den   = (state_q == S_T3) ? den_abs : b4_q;

	bpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign q_s      = neg_q ? (~div_quot + 1'b1) : div_quot;
	assign b5       = x1_q + q_s;
	assign temp_res = asr(b5 + 32'd8, 5'd4);

	// ---------------- handshakes ----------------
	assign raw.ready      = (state_q == S_IDLE);
	assign in_xfer        = raw.valid && raw.ready;
	assign out_free       = !out_valid_q || comp.ready;
	assign comp.valid     = out_valid_q;
	assign comp.kind      = out_kind_q;
	assign comp.value     = out_value_q;
	assign comp.div_error = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ti_q        <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= 1'b0;
			out_value_q <= '0;
			out_err_q   <= 1'b0;
		end else begin
			// load a new result, else drop the one just taken
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && comp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer)
						state_q <= raw.op ? S_P1 : S_T1;
				end
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= (den_q == '0) ? S_DONE : S_TDIV;
				S_TDIV: begin
					if (div_done) begin
						ti_q    <= b5;
						state_q <= S_DONE;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_P5;
				S_P5: state_q <= S_P6;
				S_P6: state_q <= S_P7;
				S_P7: state_q <= S_P8;
				S_P8: state_q <= S_P9;
				S_P9: state_q <= (b4_q == '0) ? S_DONE : S_PDIV;
				S_PDIV: begin
					if (div_done)
						state_q <= S_P10;
				end
				S_P10: state_q <= S_P11;
				S_P11: state_q <= S_P12;
				S_P12: state_q <= S_P13;
				S_P13: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						out_kind_q  <= op_q;
						out_value_q <= res_q;
						out_err_q   <= err_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		p_q <= mul_y;
		case (state_q)
			S_IDLE: begin
				op_q  <= raw.op;
				raw_q <= raw.raw_value;
				err_q <= 1'b0;
				res_q <= '0;
			end
			S_T2: begin
				x1_q  <= asr(p_q, 5'd15);
				den_q <= asr(p_q, 5'd15) + md;
			end
			S_T3: begin
				neg_q <= mc_sh[31] ^ den_q[31];
				if (den_q == '0)
					err_q <= 1'b1;
			end
			S_TDIV: begin
				if (div_done)
					res_q <= temp_res;
			end
			S_P2: sq_q  <= asr(p_q, 5'd12);
			S_P3: x1_q  <= asr(p_q, 5'd11);
			S_P4: b3_q  <= b3_next;
			S_P5: x1_q  <= asr(p_q, 5'd13);
			S_P6: x1_q  <= x3_next;
			S_P8: b4_q  <= p_q >> 15;
			S_P9: begin
				dbl_q <= !p_q[31];
				if (b4_q == '0)
					err_q <= 1'b1;
			end
			S_PDIV: begin
				if (div_done)
					pv_q <= dbl_q ? div_quot : (div_quot << 1);
			end
			S_P12: x1_q  <= asr(p_q, 5'd16);
			S_P13: res_q <= p_final;
			default: ;
		endcase
	end

	// ---------------- checks ----------------
	`BPC_ASSERT_IMPL(a_div_done_waited, div_done, (state_q == S_TDIV || state_q == S_PDIV))
	`BPC_ASSERT_IMPL(a_err_zero_value, out_valid_q && out_err_q, out_value_q == '0)
	`BPC_ASSERT_NEXT(a_div_start_busy, div_start, div_busy && !div_done)
	`BPC_ASSERT_NEXT(a_p9_nonzero_divides, state_q == S_P9 && b4_q != '0, state_q == S_PDIV)

endmodule : barometer_temp_pressure_compensation

`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for the barometer compensation block: directed table plus random readings.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;

	// Op / kind codes on the raw and comp channels
	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	localparam int PHASES      = 10;
	localparam int PER_PHASE   = 125;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int REPORT_CAP  = 40;

	// One compensated reading as it leaves the comp channel
	typedef struct {
		logic  kind;
		word_t value;
		logic  div_error;
	} reading_t;

	// One row of the directed plan: either a register write or a raw reading.
	// Rows with typed set carry their expected result directly.
	typedef struct {
		bit          is_cfg;
		reg_idx_t    idx;
		logic [63:0] data;
		logic        op;
		logic [18:0] raw;
		bit          typed;
		reading_t    want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	bpc_in_if  raw_ch ();
	bpc_out_if comp_ch ();

	barometer_temp_pressure_compensation i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.comp    (comp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the calibration registers and of the stored B5
	logic [63:0] temp_words;
	logic [63:0] press_words;
	logic [31:0] press_b;
	logic [1:0]  oss_cur;
	word_t       b5_store;

	reading_t  readings_due[$];
	plan_row_t plan[$];
	int        error_count;
	int        cycles;
	bit        calm;     // no idling on either side while set

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d readings still due", $time, readings_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	//------------------------------------------------------------------
	// Compensation predictor, 32-bit wraparound throughout
	//------------------------------------------------------------------

	// Arithmetic right shift
	function automatic word_t sra32(input word_t x, input int unsigned n);
		word_t r;
		r = x >> n;
		if (x[31])
			r = r | ~(32'hFFFF_FFFF >> n);
		return r;
	endfunction

	function automatic word_t ext16(input logic [15:0] h);
		return h[15] ? {16'hFFFF, h} : {16'h0000, h};
	endfunction

	// Signed division truncating toward zero, quotient wrapped to 32 bits
	function automatic word_t sdiv32(input word_t n, input word_t d);
		longint q;
		q = longint'($signed(n)) / longint'($signed(d));
		return q[31:0];
	endfunction

	// Expected reading for one raw conversion; a good temperature updates b5_store
	function automatic reading_t compensate(input logic op, input logic [18:0] rawv);
		reading_t r;
		word_t    raw32, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		word_t    x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p, t;
		r.kind      = op;
		r.value     = '0;
		r.div_error = 1'b0;
		raw32       = {13'd0, rawv};
		if (op == OP_TEMP) begin
			ac5 = {16'd0, temp_words[63:48]};
			ac6 = {16'd0, temp_words[47:32]};
			mc  = ext16(temp_words[31:16]);
			md  = ext16(temp_words[15:0]);
			t   = raw32 - ac6;
			x1  = sra32(t * ac5, 15);
			den = x1 + md;
			if (den == '0) begin
				// zero divisor: B5 is kept
				r.div_error = 1'b1;
			end else begin
				t        = mc * 32'd2048;
				x2       = sdiv32(t, den);
				b5       = x1 + x2;
				b5_store = b5;
				r.value  = sra32(b5 + 32'd8, 4);
			end
		end else begin
			ac1 = ext16(press_words[63:48]);
			ac2 = ext16(press_words[47:32]);
			ac3 = ext16(press_words[31:16]);
			ac4 = {16'd0, press_words[15:0]};
			b1  = ext16(press_b[31:16]);
			b2  = ext16(press_b[15:0]);
			b6  = b5_store - 32'd4000;
			sq  = sra32(b6 * b6, 12);
			x1  = sra32(b2 * sq, 11);
			x2  = sra32(ac2 * b6, 11);
			x3  = x1 + x2;
			t   = ac1 * 32'd4 + x3;
			t   = t << oss_cur;
			b3  = sra32(t + 32'd2, 2);
			x1  = sra32(ac3 * b6, 13);
			x2  = sra32(b1 * sq, 16);
			x3  = sra32(x1 + x2 + 32'd2, 2);
			t   = ac4 * (x3 + 32'd32768);
			b4  = t >> 15;
			t   = raw32 - b3;
			b7  = t * (32'd50000 >> oss_cur);
			if (b4 == '0) begin
				r.div_error = 1'b1;
			end else begin
				// unsigned divide, kept inside 32 bits either way
				if (b7 < 32'h8000_0000) begin
					t = b7 << 1;
					p = t / b4;
				end else begin
					t = b7 / b4;
					p = t << 1;
				end
				x1      = sra32(p, 8);
				x1      = x1 * x1;
				x1      = sra32(x1 * 32'd3038, 16);
				x2      = sra32(32'hFFFF_E343 * p, 16);
				p       = p + sra32(x1 + x2 + 32'd3791, 4);
				r.value = p;
			end
		end
		return r;
	endfunction

	//------------------------------------------------------------------
	// Channel drivers
	//------------------------------------------------------------------

	// Receiver: holds ready low about 36 percent of the time unless calm
	always @(posedge clk)
		comp_ch.ready <= calm || ($urandom_range(0, 99) >= 36);

	// APB write: setup, access, then an idle step so back-to-back writes
	// never lower and raise psel in the same step
	task automatic reg_write(input reg_idx_t idx, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_TEMP_CAL:  temp_words  = data;
			REG_PRESS_CAL: press_words = data;
			REG_PRESS_B:   press_b     = data[31:0];
			REG_OSS:       oss_cur     = data[1:0];
			default: ;
		endcase
	endtask

	// Sender: random gaps, then hold valid until the transfer. Returns right
	// after the accepting edge with valid still high, so a following call can
	// keep it high for the next item.
	task automatic send_reading(input logic op, input logic [18:0] v, input bit typed,
			input reading_t typed_want);
		reading_t r;
		if (!calm) begin
			while ($urandom_range(0, 99) < 36) begin
				raw_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		raw_ch.valid     <= 1'b1;
		raw_ch.op        <= op;
		raw_ch.raw_value <= v;
		do @(posedge clk); while (!raw_ch.ready);
		r = compensate(op, v);
		readings_due.push_back(typed ? typed_want : r);
	endtask

	// Stop sending and wait until every reading has come out
	task automatic drain_readings();
		raw_ch.valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	//------------------------------------------------------------------
	// Result checker
	//------------------------------------------------------------------
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && comp_ch.valid && comp_ch.ready) begin
			if (readings_due.size() == 0) begin
				if (error_count < REPORT_CAP)
					$display("%0t: unexpected transfer: kind %0d value %0d div_error %0d",
						$time, comp_ch.kind, comp_ch.value, comp_ch.div_error);
				error_count++;
			end else begin
				want = readings_due.pop_front();
				if (comp_ch.kind !== want.kind || comp_ch.value !== want.value ||
						comp_ch.div_error !== want.div_error) begin
					if (error_count < REPORT_CAP)
						$display("%0t: mismatch: expected kind %0d value %0d div_error %0d, got kind %0d value %0d div_error %0d",
							$time, want.kind, $signed(want.value), want.div_error,
							comp_ch.kind, comp_ch.value, comp_ch.div_error);
					error_count++;
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Directed plan rows
	//------------------------------------------------------------------
	function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [63:0] data);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = data;
		row.op     = OP_TEMP;
		row.raw    = '0;
		row.typed  = 1'b0;
		row.want   = '{default: '0};
		return row;
	endfunction

	function automatic plan_row_t item_row(input logic op, input logic [18:0] v);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.idx    = REG_TEMP_CAL;
		row.data   = '0;
		row.op     = op;
		row.raw    = v;
		row.typed  = 1'b0;
		row.want   = '{default: '0};
		return row;
	endfunction

	// Zero divisor: value 0 with the error flag
	function automatic plan_row_t div_err_row(input logic op, input logic [18:0] v);
		plan_row_t row;
		row                = item_row(op, v);
		row.typed          = 1'b1;
		row.want.kind      = op;
		row.want.value     = '0;
		row.want.div_error = 1'b1;
		return row;
	endfunction

	// Calibration for one random phase; a few phases pin the extremes
	task automatic program_phase(input int ph);
		case (ph % 5)
			0: begin
				// datasheet-like calibration
				reg_write(REG_TEMP_CAL,  64'h7FF5_5A71_DDF9_0B34);
				reg_write(REG_PRESS_CAL, 64'h0198_FFB8_C7D1_7FE5);
				reg_write(REG_PRESS_B,   64'h0000_0000_182E_0004);
				reg_write(REG_OSS,       {$urandom(), $urandom()});
			end
			1: begin
				reg_write(REG_TEMP_CAL,  64'hFFFF_FFFF_FFFF_FFFF);
				reg_write(REG_PRESS_CAL, 64'hFFFF_FFFF_FFFF_FFFF);
				reg_write(REG_PRESS_B,   64'hFFFF_FFFF_FFFF_FFFF);
				reg_write(REG_OSS,       64'd3);
			end
			3: begin
				reg_write(REG_TEMP_CAL,  64'h0000_0000_8000_8000);
				reg_write(REG_PRESS_CAL, 64'h8000_8000_8000_0001);
				reg_write(REG_PRESS_B,   64'h0000_0000_8000_8000);
				reg_write(REG_OSS,       64'd0);
			end
			default: begin
				reg_write(REG_TEMP_CAL,  {$urandom(), $urandom()});
				reg_write(REG_PRESS_CAL, {$urandom(), $urandom()});
				reg_write(REG_PRESS_B,   {$urandom(), $urandom()});
				reg_write(REG_OSS,       {$urandom(), $urandom()});
			end
		endcase
	endtask

	//------------------------------------------------------------------
	// Main sequence
	//------------------------------------------------------------------
	initial begin
		logic        op;
		logic [18:0] v;
		int          sel;

		arst_n           = 1'b0;
		calm             = 1'b0;
		error_count      = 0;
		cycles           = 0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		raw_ch.valid     = 1'b0;
		raw_ch.op        = OP_TEMP;
		raw_ch.raw_value = '0;
		comp_ch.ready    = 1'b0;
		temp_words       = '0;
		press_words      = '0;
		press_b          = '0;
		oss_cur          = '0;
		b5_store         = '0;

		// Out of reset every divisor is zero, whatever the raw value
		plan.push_back(div_err_row(OP_TEMP,  19'h00000));
		plan.push_back(div_err_row(OP_PRESS, 19'h00000));
		plan.push_back(div_err_row(OP_TEMP,  19'h7FFFF));
		plan.push_back(div_err_row(OP_PRESS, 19'h7FFFF));
		// Datasheet calibration, then the field extremes
		plan.push_back(cfg_row(REG_TEMP_CAL,  64'h7FF5_5A71_DDF9_0B34));
		plan.push_back(cfg_row(REG_PRESS_CAL, 64'h0198_FFB8_C7D1_7FE5));
		plan.push_back(cfg_row(REG_PRESS_B,   64'h0000_0000_182E_0004));
		plan.push_back(cfg_row(REG_OSS,       64'd0));
		plan.push_back(item_row(OP_TEMP,  19'd27898));
		plan.push_back(item_row(OP_PRESS, 19'd23843));
		plan.push_back(item_row(OP_TEMP,  19'h00000));
		plan.push_back(item_row(OP_TEMP,  19'h7FFFF));   // wide temperature raw
		plan.push_back(item_row(OP_PRESS, 19'h00000));
		plan.push_back(item_row(OP_PRESS, 19'h7FFFF));
		// Highest oversampling
		plan.push_back(cfg_row(REG_OSS, 64'd3));
		plan.push_back(item_row(OP_PRESS, 19'h7FFFF));
		plan.push_back(item_row(OP_PRESS, 19'd95372));
		plan.push_back(item_row(OP_PRESS, 19'h00000));
		// ac5 = md = 0: temperature divisor is zero, B5 must survive it
		plan.push_back(cfg_row(REG_TEMP_CAL, 64'h0000_5A71_DDF9_0000));
		plan.push_back(div_err_row(OP_TEMP, 19'd27898));
		plan.push_back(item_row(OP_PRESS, 19'd23843));
		// Temperature calibration at its extremes
		plan.push_back(cfg_row(REG_TEMP_CAL, 64'hFFFF_FFFF_8000_7FFF));
		plan.push_back(item_row(OP_TEMP, 19'h00000));
		plan.push_back(item_row(OP_TEMP, 19'h7FFFF));
		plan.push_back(item_row(OP_TEMP, 19'h05555));
		// Pressure calibration at its extremes
		plan.push_back(cfg_row(REG_PRESS_CAL, 64'h8000_8000_8000_FFFF));
		plan.push_back(cfg_row(REG_PRESS_B,   64'h0000_0000_7FFF_8000));
		plan.push_back(item_row(OP_PRESS, 19'h7FFFF));
		plan.push_back(item_row(OP_PRESS, 19'h00000));
		// ac4 = 0: pressure divisor B4 is zero
		plan.push_back(cfg_row(REG_PRESS_CAL, 64'h7FFF_7FFF_7FFF_0000));
		plan.push_back(div_err_row(OP_PRESS, 19'h2AAAA));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				// registers change only with nothing in flight
				drain_readings();
				reg_write(plan[i].idx, plan[i].data);
			end else begin
				send_reading(plan[i].op, plan[i].raw, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each with its own calibration
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_readings();
			calm = (ph == 6);
			program_phase(ph);
			for (int n = 0; n < PER_PHASE; n++) begin
				op  = $urandom_range(0, 1) ? OP_PRESS : OP_TEMP;
				sel = $urandom_range(0, 99);
				if (sel < 5)
					v = 19'h7FFFF;
				else if (sel < 10)
					v = 19'h00000;
				else if (op == OP_TEMP && sel < 80)
					v = {3'b000, 16'($urandom())};
				else
					v = 19'($urandom());
				send_reading(op, v, 1'b0, '{default: '0});
				// once, let the block run dry mid-phase
				if (ph == 3 && n == 60)
					drain_readings();
			end
		end
		calm = 1'b0;

		drain_readings();
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule : tb_top

@@ sim.f @@
+incdir+rtl
rtl/bpc_pkg.sv
rtl/bpc_in_if.sv
rtl/bpc_out_if.sv
rtl/bpc_div.sv
rtl/barometer_temp_pressure_compensation.sv
dv/tb_top.sv
